>>> rtl/mpss_pkg.sv
package mpss_pkg;

  localparam int DATA_W           = 16;
  localparam int CH_W             = 3;
  localparam int LINES_W          = 5;
  localparam int NUM_WIDTH_REGS   = 5;
  localparam int NUM_CHANNELS_DEF = 5;
  localparam int CFG_IDX_W        = 3;

  localparam logic [DATA_W-1:0] SLOT_RESET = DATA_W'(8000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_CH0  = 3'd0,
    REG_WIDTH_CH1  = 3'd1,
    REG_WIDTH_CH2  = 3'd2,
    REG_WIDTH_CH3  = 3'd3,
    REG_WIDTH_CH4  = 3'd4,
    REG_SLOT_TICKS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_WIDTH_REGS-1:0][DATA_W-1:0] width;
    logic [DATA_W-1:0]                     slot;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic tick;
  } step_ctrl_t;

  typedef struct packed {
    logic [LINES_W-1:0] lines;
    logic [CH_W-1:0]    chan;
    logic               frame_start;
  } res_t;

endpackage

>>> rtl/mpss_cfg.sv
module mpss_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mpss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpss_pkg::DATA_W-1:0]         cfg_data,
  output mpss_pkg::cfg_t                      cfg
);
  import mpss_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH_CH0:  cfg_nxt.width[0] = cfg_data;
        REG_WIDTH_CH1:  cfg_nxt.width[1] = cfg_data;
        REG_WIDTH_CH2:  cfg_nxt.width[2] = cfg_data;
        REG_WIDTH_CH3:  cfg_nxt.width[3] = cfg_data;
        REG_WIDTH_CH4:  cfg_nxt.width[4] = cfg_data;
        REG_SLOT_TICKS: cfg_nxt.slot     = cfg_data;
        default:        ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width <= '0;
      cfg_r.slot  <= SLOT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/mpss_step.sv
module mpss_step #(
  parameter int NUM_CHANNELS = mpss_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpss_pkg::cfg_t      cfg,
  input  mpss_pkg::step_ctrl_t ctrl,
  output mpss_pkg::res_t      res
);
  import mpss_pkg::*;

  logic [CH_W-1:0]   cur_r, cur_nxt;
  logic              high_r, high_nxt;
  logic [DATA_W-1:0] tl_r, tl_nxt;

  logic [DATA_W-1:0] slot_len;
  logic [DATA_W-1:0] w_cur, w_adv, w_begin, low_len;
  logic [CH_W-1:0]   cur_adv, cur_a, cur_wrap;
  logic              high_a, begin_slot, fs;
  logic [DATA_W-1:0] tl_a, tl_dec;

  function automatic logic [CH_W-1:0] next_ch(input logic [CH_W-1:0] ch);
    logic [CH_W:0] n;
    n = {1'b0, ch} + (CH_W+1)'(1);
    return (n >= (CH_W+1)'(NUM_CHANNELS)) ? '0 : n[CH_W-1:0];
  endfunction

  // width of a channel, clamped to the slot; channels without a register are 0
  function automatic logic [DATA_W-1:0] eff_width(input logic [CH_W-1:0] ch,
                                                   input cfg_t c,
                                                   input logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] w;
    w = '0;
    for (int i = 0; i < NUM_WIDTH_REGS; i++) begin
      if (ch == CH_W'(i)) w = c.width[i];
    end
    return (w > s) ? s : w;
  endfunction

  always_comb begin
    slot_len = (cfg.slot == '0) ? DATA_W'(1) : cfg.slot;
    cur_adv  = next_ch(cur_r);
    w_cur    = eff_width(cur_r, cfg, slot_len);
    w_adv    = eff_width(cur_adv, cfg, slot_len);
    low_len  = slot_len - w_cur;

    cur_a      = cur_r;
    high_a     = high_r;
    tl_a       = tl_r;
    fs         = 1'b0;
    begin_slot = 1'b0;
    w_begin    = w_cur;

    if (ctrl.tick && tl_r == '0) begin
      begin_slot = 1'b1;
      if (high_r) begin
        if (low_len != '0) begin
          high_a     = 1'b0;
          tl_a       = low_len;
          begin_slot = 1'b0;
        end else begin
          cur_a   = cur_adv;
          w_begin = w_adv;
        end
      end
      if (begin_slot) begin
        fs = (cur_a == '0);
        if (w_begin != '0) begin
          high_a = 1'b1;
          tl_a   = w_begin;
        end else begin
          high_a = 1'b0;
          tl_a   = slot_len;
        end
      end
    end

    tl_dec   = tl_a - DATA_W'(1);
    cur_wrap = (tl_dec == '0 && !high_a) ? next_ch(cur_a) : cur_a;

    for (int i = 0; i < LINES_W; i++) begin
      res.lines[i] = high_a && (cur_a == CH_W'(i));
    end
    res.chan        = cur_a;
    res.frame_start = fs;

    cur_nxt  = cur_r;
    high_nxt = high_r;
    tl_nxt   = tl_r;
    if (ctrl.fire && ctrl.tick) begin
      cur_nxt  = cur_wrap;
      high_nxt = high_a;
      tl_nxt   = tl_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      high_r <= 1'b0;
      tl_r   <= '0;
    end else begin
      cur_r  <= cur_nxt;
      high_r <= high_nxt;
      tl_r   <= tl_nxt;
    end
  end

`ifndef SYNTHESIS
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_r} < (CH_W+1)'(NUM_CHANNELS)))
    else $error("channel index out of range");

  a_lines_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(res.lines))
    else $error("more than one servo line high");

  a_fs_chan0: assert property (@(posedge clk) disable iff (!rst_n)
    res.frame_start |-> (res.chan == '0) && ctrl.tick)
    else $error("frame start outside channel 0");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.fire && ctrl.tick) |=> $stable(cur_r) && $stable(high_r) && $stable(tl_r))
    else $error("state moved without a tick");
`endif

endmodule

>>> rtl/multiplexed_servo_pulse_sequencer_top.sv
// Multiplexed servo pulse sequencer. Each transfer on the in_ channel is one
// timer tick (in_tick=1 advances time, in_tick=0 just samples the present state)
// and yields exactly one transfer on the out_ channel. Channels 0 to
// NUM_CHANNELS-1 get a slot of slot_ticks ticks each in turn; the active line
// is high for min(width_chN, slot) ticks and low for the rest of the slot.
// Zero width gives an all-low slot, zero slot_ticks acts as one tick. Channels
// above 4 have no width register and stay low. An input stage register and a
// result register sit on either side of a single pass of update logic, and one
// item can be taken every clock while out_ready does not hold the output back.
// Registers reset to width 0 and a slot of 8000 ticks.
module multiplexed_servo_pulse_sequencer_top #(
  parameter int NUM_CHANNELS = mpss_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_tick,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpss_pkg::LINES_W-1:0]    out_servo_lines,
  output logic [mpss_pkg::CH_W-1:0]       out_active_channel,
  output logic                            out_frame_start,
  // register writes
  input  logic                            cfg_we,
  input  logic [mpss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpss_pkg::DATA_W-1:0]     cfg_data
);
  import mpss_pkg::*;

  cfg_t       cfg;
  step_ctrl_t ctrl;
  res_t       res;

  // input stage
  logic s1_valid_r, s1_valid_nxt;
  logic s1_tick_r;
  // result register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  logic advance;

  // The stage moves on when the result register is free or being drained
  // in the same cycle, so with out_ready high a steady stream runs at one transfer per clock.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (advance) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_tick_r <= in_tick;
    if (advance) out_res_r <= res;
  end

  assign ctrl.fire = advance;
  assign ctrl.tick = s1_tick_r;

  mpss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // slot countdown, phase and channel rotation
  mpss_step #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .ctrl  (ctrl),
    .res   (res)
  );

  assign out_valid          = out_valid_r;
  assign out_servo_lines    = out_res_r.lines;
  assign out_active_channel = out_res_r.chan;
  assign out_frame_start    = out_res_r.frame_start;

endmodule
